// ===== src/pltd_pkg.sv =====
// Shared types and constants for the preamble/length/tail deframer.
package pltd_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned LEN_W  = 7;

  localparam logic [BYTE_W-1:0] SYNC_A = 8'hA5;
  localparam logic [BYTE_W-1:0] SYNC_B = 8'h5A;
  localparam logic [BYTE_W-1:0] TAIL_A = 8'hFA;
  localparam logic [BYTE_W-1:0] TAIL_B = 8'hFB;

  // Byte position that carries the low length byte, counted from one.
  localparam logic [LEN_W-1:0] LEN_LO_COUNT = 7'd4;
  // Byte position (from zero) that carries the high length byte.
  localparam logic [LEN_W-1:0] LEN_HI_POS   = 7'd2;

  typedef enum logic [2:0] {
    PH_HUNT1 = 3'b001,
    PH_HUNT2 = 3'b010,
    PH_DATA  = 3'b100
  } phase_t;

  // Parser to read-out request: a frame with a good tail is complete.
  typedef struct packed {
    logic             start;
    logic [LEN_W-1:0] len;
  } frame_req_t;

endpackage

// ===== src/pltd_store.sv =====
// Frame store: synchronous memory, one write port and one registered read port.
module pltd_store import pltd_pkg::*; #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [BYTE_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output logic [BYTE_W-1:0] rd_q
);

  logic [BYTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read data holds when no read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

endmodule

// ===== src/pltd_parse.sv =====
// Byte parser: preamble hunt, length check, tail check, frame store writes.
module pltd_parse import pltd_pkg::*; #(
  parameter int unsigned MAX_LEN  = 64,
  parameter int unsigned OVERHEAD = 6,
  parameter int unsigned AW       = 6
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  logic [BYTE_W-1:0] rx_byte,
  output logic              wr_en,
  output logic [AW-1:0]     wr_addr,
  output logic [BYTE_W-1:0] wr_data,
  output frame_req_t        req
);

  localparam logic [LEN_W-1:0]  MAX_L = LEN_W'(MAX_LEN);
  localparam logic [BYTE_W-1:0] MAX_B = BYTE_W'(MAX_LEN);
  localparam logic [BYTE_W-1:0] OVH_B = BYTE_W'(OVERHEAD);

  phase_t            phase, phase_next;
  logic [LEN_W-1:0]  count, count_next;
  logic [LEN_W-1:0]  decl, decl_next;
  logic [BYTE_W-1:0] hi_byte;
  logic [BYTE_W-1:0] last_byte;

  logic [LEN_W-1:0]  cnt1;
  logic [LEN_W-1:0]  dl;
  logic              len_ok;
  logic              restart;

  always_comb begin
    phase_next = phase;
    count_next = count;
    decl_next  = decl;
    wr_en      = 1'b0;
    wr_addr    = count[AW-1:0];
    wr_data    = rx_byte;
    req        = '0;
    restart    = 1'b0;
    cnt1       = count + LEN_W'(1);
    dl         = decl;
    len_ok     = (hi_byte == '0) && (rx_byte >= OVH_B) && (rx_byte <= MAX_B) &&
                 (rx_byte[0] == OVH_B[0]);
    if (take) begin
      unique case (phase)
        PH_HUNT2: begin
          if (rx_byte == SYNC_B) begin
            wr_en      = 1'b1;
            wr_addr    = AW'(1);
            count_next = LEN_W'(2);
            phase_next = PH_DATA;
          end else begin
            restart = 1'b1;
          end
        end
        PH_DATA: begin
          if (count >= MAX_L) begin
            restart = 1'b1;
          end else begin
            wr_en      = 1'b1;
            count_next = cnt1;
            if (cnt1 == LEN_LO_COUNT) begin
              if (!len_ok) begin
                restart = 1'b1;
              end else begin
                decl_next = rx_byte[LEN_W-1:0];
                dl        = rx_byte[LEN_W-1:0];
              end
            end
            if (!restart && (dl != '0) && (cnt1 == dl)) begin
              req.start  = (last_byte == TAIL_A) && (rx_byte == TAIL_B);
              req.len    = dl;
              phase_next = PH_HUNT1;
              count_next = '0;
              decl_next  = '0;
            end
          end
        end
        default: begin
          restart = 1'b1;
        end
      endcase
      if (restart) begin
        decl_next = '0;
        if (rx_byte == SYNC_A) begin
          wr_en      = 1'b1;
          wr_addr    = '0;
          count_next = LEN_W'(1);
          phase_next = PH_HUNT2;
        end else begin
          wr_en      = 1'b0;
          count_next = '0;
          phase_next = PH_HUNT1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HUNT1;
      count <= '0;
      decl  <= '0;
    end else begin
      phase <= phase_next;
      count <= count_next;
      decl  <= decl_next;
    end
  end

  // Keep the high length byte and the previous byte for the checks.
  always_ff @(posedge clk) begin
    if (take) begin
      last_byte <= rx_byte;
      if (phase == PH_DATA && count == LEN_HI_POS) begin
        hi_byte <= rx_byte;
      end
    end
  end

endmodule

// ===== src/pltd_emit.sv =====
// Read-out: walks the frame store and delivers bytes through an output register.
module pltd_emit import pltd_pkg::*; #(
  parameter int unsigned AW = 6
) (
  input  logic              clk,
  input  logic              rst,
  input  frame_req_t        req,
  output logic              busy,
  output logic              rd_en,
  output logic [AW-1:0]     rd_addr,
  input  logic [BYTE_W-1:0] rd_q,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [BYTE_W-1:0] frame_byte,
  output logic [LEN_W-1:0]  frame_length,
  output logic              last_of_frame
);

  logic             rd_busy;
  logic [LEN_W-1:0] rd_idx;
  logic [LEN_W-1:0] rd_len;
  logic             q_valid;
  logic [LEN_W-1:0] q_len;
  logic             q_last;
  logic             o_valid;
  logic [BYTE_W-1:0] o_byte;
  logic [LEN_W-1:0] o_len;
  logic             o_last;

  logic move;
  logic issue;
  logic idx_last;

  assign move     = q_valid && (!o_valid || !out_stall);
  assign issue    = rd_busy && (!q_valid || move);
  assign idx_last = (rd_idx == rd_len - LEN_W'(1));

  assign busy    = rd_busy;
  assign rd_en   = issue;
  assign rd_addr = rd_idx[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_busy <= 1'b0;
      q_valid <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      if (req.start) begin
        rd_busy <= 1'b1;
      end else if (issue && idx_last) begin
        rd_busy <= 1'b0;
      end
      if (issue) begin
        q_valid <= 1'b1;
      end else if (move) begin
        q_valid <= 1'b0;
      end
      if (move) begin
        o_valid <= 1'b1;
      end else if (!out_stall) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rd_idx <= '0;
      rd_len <= req.len;
    end else if (issue) begin
      rd_idx <= rd_idx + LEN_W'(1);
    end
    if (issue) begin
      q_len  <= rd_len;
      q_last <= idx_last;
    end
    if (move) begin
      o_byte <= rd_q;
      o_len  <= q_len;
      o_last <= q_last;
    end
  end

  assign out_valid     = o_valid;
  assign frame_byte    = o_byte;
  assign frame_length  = o_len;
  assign last_of_frame = o_last;

endmodule

// ===== src/preamble_length_tail_deframer_core.sv =====
// Top level of the preamble/length/tail deframer.
// Received bytes enter one per cycle on the input channel. The parser hunts
// for the preamble A5 5A, takes bytes 2 and 3 as a big-endian total frame
// length (valid when OVERHEAD <= length <= MAX_LEN and length - OVERHEAD is
// even), and writes every frame byte into a MAX_LEN-entry frame store. A bad
// second preamble byte or a bad length restarts the hunt on that same byte.
// When the byte count reaches the length, a frame ending in FA FB is read
// back out of the store, one item per frame byte, each carrying the frame
// length and a last-byte mark; a frame with any other tail is dropped.
// Throughput: while parsing, one input item per cycle. After a good frame of
// L bytes, in_stall stays high until the store's single read port has issued
// all L reads; output items that back up behind out_stall hold those reads
// off. Output items follow one per cycle behind the registered store read
// and the output register while out_stall is low. The output register lets
// the next frame's bytes be taken while the final items of the previous
// frame still wait.
module preamble_length_tail_deframer_core import pltd_pkg::*; #(
  parameter int unsigned MAX_LEN  = 64,
  parameter int unsigned OVERHEAD = 6
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [BYTE_W-1:0] rx_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [BYTE_W-1:0] frame_byte,
  output logic [LEN_W-1:0]  frame_length,
  output logic              last_of_frame
);

  localparam int unsigned AW = $clog2(MAX_LEN);

  logic              take;
  logic              busy;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [BYTE_W-1:0] wr_data;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [BYTE_W-1:0] rd_q;
  frame_req_t        req;

  // Hold the input off while the store is being read out.
  assign in_stall = busy;
  assign take     = in_valid && !in_stall;

  pltd_parse #(
    .MAX_LEN  (MAX_LEN),
    .OVERHEAD (OVERHEAD),
    .AW       (AW)
  ) u_parse (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .rx_byte (rx_byte),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .req     (req)
  );

  pltd_store #(
    .DEPTH (MAX_LEN),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_q    (rd_q)
  );

  pltd_emit #(
    .AW (AW)
  ) u_emit (
    .clk           (clk),
    .rst           (rst),
    .req           (req),
    .busy          (busy),
    .rd_en         (rd_en),
    .rd_addr       (rd_addr),
    .rd_q          (rd_q),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .frame_byte    (frame_byte),
    .frame_length  (frame_length),
    .last_of_frame (last_of_frame)
  );

endmodule

// ===== src/pltd_check.sv =====
// Port-level checker for the deframer, bound to the top level.
module pltd_check import pltd_pkg::*; #(
  parameter int unsigned MAX_LEN  = 64,
  parameter int unsigned OVERHEAD = 6
) (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_stall,
  input logic [BYTE_W-1:0] frame_byte,
  input logic [LEN_W-1:0]  frame_length,
  input logic              last_of_frame
);

  localparam logic [LEN_W-1:0] MAX_L = LEN_W'(MAX_LEN);
  localparam logic [LEN_W-1:0] OVH_L = LEN_W'(OVERHEAD);

  logic [LEN_W-1:0] pos;
  logic             out_take;

  assign out_take = out_valid && !out_stall;

  // Count delivered items within the current frame.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (out_take) begin
      pos <= last_of_frame ? '0 : pos + LEN_W'(1);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(frame_byte) &&
      $stable(frame_length) && $stable(last_of_frame))
    else $error("output item changed while stalled");

  a_len_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> frame_length >= OVH_L && frame_length <= MAX_L &&
      frame_length[0] == OVH_L[0])
    else $error("emitted frame length is not a legal length");

  a_last_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_of_frame |-> LEN_W'(pos + LEN_W'(1)) == frame_length &&
      frame_byte == TAIL_B)
    else $error("last mark not on the final tail byte");

  a_mid_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_of_frame |-> LEN_W'(pos + LEN_W'(1)) < frame_length)
    else $error("frame runs past its length");

  a_first_sync: assert property (@(posedge clk) disable iff (rst)
    out_valid && pos == '0 |-> frame_byte == SYNC_A)
    else $error("frame does not start with the preamble");

endmodule

bind preamble_length_tail_deframer_core pltd_check #(
  .MAX_LEN  (MAX_LEN),
  .OVERHEAD (OVERHEAD)
) u_pltd_check (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .frame_byte    (frame_byte),
  .frame_length  (frame_length),
  .last_of_frame (last_of_frame)
);

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the preamble/length/tail deframer core.
module tb;
  import pltd_pkg::*;

  localparam int unsigned MAX_LEN      = 64;
  localparam int unsigned OVERHEAD     = 6;
  localparam int unsigned ITEM_TARGET  = 460;
  // Longest frame read-out plus the output register, with margin.
  localparam int unsigned DRAIN_CYCLES = 160;
  localparam int unsigned EMPTY_LIMIT  = 20000;

  // Marks a table row whose results come from the predictor.
  localparam logic signed [7:0] PREDICT = -8'sd1;

  // One stimulus row: the byte to send and, where typed in, how many of the
  // most recently fed bytes come straight back out as one frame.
  typedef struct packed {
    logic [BYTE_W-1:0] rx;
    logic signed [7:0] echo_len;
  } stim_row_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic [LEN_W-1:0]  len;
    logic              last;
  } frame_item_t;

  logic              clk           = 1'b0;
  logic              rst           = 1'b1;
  logic              in_valid      = 1'b0;
  logic              in_stall;
  logic [BYTE_W-1:0] rx_byte       = '0;
  logic              out_valid;
  logic              out_stall     = 1'b0;
  logic [BYTE_W-1:0] frame_byte;
  logic [LEN_W-1:0]  frame_length;
  logic              last_of_frame;

  preamble_length_tail_deframer_core #(
    .MAX_LEN  (MAX_LEN),
    .OVERHEAD (OVERHEAD)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .rx_byte       (rx_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .frame_byte    (frame_byte),
    .frame_length  (frame_length),
    .last_of_frame (last_of_frame)
  );

  always #6 clk = ~clk;

  // Directed table: bad second preamble byte retested as A5, a length with a
  // nonzero high byte whose low byte restarts the hunt, and a bad tail whose
  // last byte (A5) must not open a new preamble.
  stim_row_t directed_rows [25] = '{
    '{SYNC_A, PREDICT}, '{SYNC_A, PREDICT}, '{SYNC_B, PREDICT},
    '{8'h00, PREDICT},  '{8'h08, PREDICT},  '{8'h00, PREDICT},
    '{8'hFF, PREDICT},  '{TAIL_A, PREDICT}, '{TAIL_B, 8'sd8},
    '{SYNC_A, PREDICT}, '{SYNC_B, PREDICT}, '{8'h01, PREDICT},
    '{SYNC_A, PREDICT}, '{SYNC_B, PREDICT}, '{8'h00, PREDICT},
    '{8'h06, PREDICT},  '{TAIL_A, PREDICT}, '{TAIL_B, 8'sd6},
    '{SYNC_A, PREDICT}, '{SYNC_B, PREDICT}, '{8'h00, PREDICT},
    '{8'h06, PREDICT},  '{TAIL_B, PREDICT}, '{SYNC_A, 8'sd0},
    '{SYNC_B, PREDICT}
  };

  stim_row_t         stim_q[$];
  stim_row_t         bus_row;
  frame_item_t       pending_frame_bytes[$];
  logic [BYTE_W-1:0] fed_history[$];
  int unsigned       stim_total     = 0;
  int unsigned       bytes_fed      = 0;
  int unsigned       mismatch_count = 0;
  int unsigned       idle_mode      = 0;

  // Deframer state as the predictor sees it.
  phase_t            dfr_phase = PH_HUNT1;
  logic [LEN_W-1:0]  dfr_count = '0;
  logic [LEN_W-1:0]  dfr_len   = '0;
  logic [BYTE_W-1:0] dfr_store [MAX_LEN];

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH %s", $time, msg);
    mismatch_count++;
  endtask

  // Drop the partial frame; take this byte as a fresh A5 if it is one.
  task automatic restart_hunt(input logic [BYTE_W-1:0] b);
    dfr_count = '0;
    dfr_len   = '0;
    dfr_phase = PH_HUNT1;
    if (b == SYNC_A) begin
      dfr_store[0] = b;
      dfr_count    = 7'd1;
      dfr_phase    = PH_HUNT2;
    end
  endtask

  // Advance the deframer by one received byte; return the frame it emits.
  task automatic deframe_byte(input logic [BYTE_W-1:0] b, output frame_item_t items[$]);
    int unsigned      len16;
    logic [LEN_W-1:0] pos;
    bit               restarted;
    int unsigned      i;
    items     = {};
    restarted = 1'b0;
    case (dfr_phase)
      PH_HUNT2: begin
        if (b == SYNC_B) begin
          dfr_store[1] = b;
          dfr_count    = 7'd2;
          dfr_phase    = PH_DATA;
        end else begin
          restart_hunt(b);
        end
      end
      PH_DATA: begin
        if (dfr_count >= MAX_LEN) begin
          restart_hunt(b);
        end else begin
          dfr_store[dfr_count[5:0]] = b;
          dfr_count = dfr_count + 1'b1;
          if (dfr_count == LEN_LO_COUNT) begin
            // Check the length on all 16 bits.
            len16 = {dfr_store[LEN_HI_POS[5:0]], b};
            if (len16 < OVERHEAD || len16 > MAX_LEN || ((len16 - OVERHEAD) % 2) != 0) begin
              restart_hunt(b);
              restarted = 1'b1;
            end else begin
              dfr_len = len16[LEN_W-1:0];
            end
          end
          if (!restarted && dfr_len != 0 && dfr_count == dfr_len) begin
            pos = dfr_len - 7'd2;
            if (dfr_store[pos[5:0]] == TAIL_A && dfr_store[pos[5:0] + 6'd1] == TAIL_B) begin
              for (i = 0; i < dfr_len; i++)
                items.push_back('{dfr_store[i[5:0]], dfr_len, i == dfr_len - 1});
            end
            // The closing byte is never retested as a preamble.
            dfr_count = '0;
            dfr_len   = '0;
            dfr_phase = PH_HUNT1;
          end
        end
      end
      default: restart_hunt(b);
    endcase
  endtask

  // Record an accepted byte and queue the frame bytes it should release.
  task automatic take_byte(input stim_row_t row);
    frame_item_t produced[$];
    int          n;
    int          i;
    deframe_byte(row.rx, produced);
    fed_history.push_back(row.rx);
    if (fed_history.size() > MAX_LEN) void'(fed_history.pop_front());
    if (row.echo_len < 0) begin
      foreach (produced[j]) pending_frame_bytes.push_back(produced[j]);
    end else begin
      n = row.echo_len;
      for (i = 0; i < n; i++)
        pending_frame_bytes.push_back('{fed_history[fed_history.size() - n + i],
                                        LEN_W'(n), i == n - 1});
    end
  endtask

  task automatic push_byte(input logic [BYTE_W-1:0] b);
    stim_q.push_back('{b, PREDICT});
  endtask

  // Queue one well-formed frame with random payload; optionally spoil the tail.
  task automatic push_frame(input int unsigned flen, input bit good_tail);
    int unsigned i;
    push_byte(SYNC_A);
    push_byte(SYNC_B);
    push_byte(8'h00);
    push_byte(8'(flen));
    for (i = 4; i < flen - 2; i++) push_byte(8'($urandom_range(255)));
    if (good_tail) begin
      push_byte(TAIL_A);
      push_byte(TAIL_B);
    end else begin
      push_byte($urandom_range(1) ? TAIL_A : 8'($urandom_range(255)));
      push_byte(8'($urandom_range(255)));
    end
  endtask

  // Idle percentage per mode: none, sender gaps, receiver stalls, both light.
  function automatic int unsigned idle_pct(input int unsigned mode, input bit sink_side);
    case (mode)
      1:       return sink_side ? 0 : 47;
      2:       return sink_side ? 47 : 0;
      3:       return 8;
      default: return 0;
    endcase
  endfunction

  // Input side: hold the item while stalled, advance on acceptance.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        take_byte(bus_row);
        bytes_fed++;
      end
      if (!in_valid || !in_stall) begin
        if (stim_q.size() != 0 && $urandom_range(99) >= idle_pct(idle_mode, 1'b0)) begin
          bus_row = stim_q.pop_front();
          in_valid <= 1'b1;
          rx_byte  <= bus_row.rx;
        end else begin
          in_valid <= 1'b0;
        end
      end
      // Step through the idle modes by quarters of the stimulus.
      idle_mode <= (bytes_fed * 4) / stim_total;
    end
  end

  // Output side: check each accepted item against the oldest expectation.
  always @(posedge clk) begin
    frame_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_frame_bytes.size() == 0) begin
        report_mismatch($sformatf("item with nothing expected: byte %02h len %0d last %0b",
                                  frame_byte, frame_length, last_of_frame));
      end else begin
        want = pending_frame_bytes.pop_front();
        if (frame_byte !== want.data)
          report_mismatch($sformatf("frame_byte %02h, want %02h", frame_byte, want.data));
        if (frame_length !== want.len)
          report_mismatch($sformatf("frame_length %0d, want %0d", frame_length, want.len));
        if (last_of_frame !== want.last)
          report_mismatch($sformatf("last_of_frame %0b, want %0b", last_of_frame, want.last));
      end
    end
    out_stall <= ($urandom_range(99) < idle_pct(idle_mode, 1'b1));
  end

  initial begin
    int unsigned r;
    int unsigned k;
    int unsigned flen;
    int unsigned waited;
    logic [BYTE_W-1:0] b;

    foreach (directed_rows[i]) stim_q.push_back(directed_rows[i]);

    // Mostly good frames with random payload; the rest broken lengths,
    // broken preambles and line noise.
    while (stim_q.size() < ITEM_TARGET) begin
      r = $urandom_range(99);
      if (r < 70) begin
        k = $urandom_range(9);
        if (k == 0)
          flen = MAX_LEN;
        else if (k == 1)
          flen = OVERHEAD + 2 * $urandom_range((MAX_LEN - OVERHEAD) / 2);
        else
          flen = OVERHEAD + 2 * $urandom_range(7);
        push_frame(flen, $urandom_range(99) < 85);
      end else if (r < 85) begin
        push_byte(SYNC_A);
        push_byte(SYNC_B);
        case ($urandom_range(4))
          0: begin  // odd distance from the overhead
            push_byte(8'h00);
            push_byte(8'(OVERHEAD + 1 + 2 * $urandom_range(28)));
          end
          1: begin  // shorter than the overhead
            push_byte(8'h00);
            push_byte(8'($urandom_range(OVERHEAD - 1)));
          end
          2: begin  // longer than the maximum
            push_byte(8'h00);
            push_byte(8'($urandom_range(255, MAX_LEN + 1)));
          end
          3: begin  // nonzero high byte
            push_byte(8'($urandom_range(255, 1)));
            push_byte(8'($urandom_range(255)));
          end
          default: begin  // low byte opens a new preamble
            push_byte(8'h00);
            push_byte(SYNC_A);
          end
        endcase
      end else if (r < 93) begin
        b = 8'($urandom_range(255));
        if (b == SYNC_B) b = SYNC_A;
        push_byte(SYNC_A);
        push_byte(b);
      end else begin
        repeat ($urandom_range(4, 1)) push_byte(8'($urandom_range(255)));
      end
    end
    stim_total = stim_q.size();

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    wait (bytes_fed == stim_total);
    waited = 0;
    while (pending_frame_bytes.size() != 0 && waited < EMPTY_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    // Let any stray frame read-out surface.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_frame_bytes.size() != 0)
      report_mismatch($sformatf("%0d frame bytes never arrived", pending_frame_bytes.size()));

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Hard stop, far beyond the slowest correct run.
  initial begin
    #(12 * 200000);
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== files.f =====
src/pltd_pkg.sv
src/pltd_store.sv
src/pltd_parse.sv
src/pltd_emit.sv
src/preamble_length_tail_deframer_core.sv
src/pltd_check.sv
tb/sv/tb.sv
